// ===== hdl/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

    // default build sizes
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDRESS_BITS_DEF = 64;

    // fixed field widths
    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 32;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // operation codes
    localparam logic OP_SINGLE = 1'b0;
    localparam logic OP_MODIFY = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        t_outcome           outcome;
        logic               last;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] eviction_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_we;
        logic mem_re;
        logic cmp_en;
        logic commit;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/salc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl
    import salc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_op,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_CMP   = 5'b01000,
        S_WR    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_mod, n_mod;
    logic   r_second, n_second;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_mod    = r_mod;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_mod        = (i_in_op == OP_MODIFY);
                    n_second     = 1'b0;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                o_cmd.mem_re = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.last   = !r_mod || r_second;
                    if (r_mod && !r_second) begin
                        n_second = 1'b1;
                        n_state  = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_mod    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mod    <= n_mod;
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/salc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LVLS     = WAY_W;
    localparam int PAD      = 1 << LVLS;
    localparam int KEY_W    = STAMP_W + 1;

    // configuration registers
    logic [2:0] r_set_bits;
    logic [3:0] r_ways;
    logic [5:0] r_block_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways       <= 4'd1;
            r_block_bits <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request address and access stamp
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [STAMP_W-1:0]      r_stamp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr <= i_in_data.address[ADDRESS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else if (i_cmd.accept && (r_stamp != '1)) begin
            r_stamp <= r_stamp + 1'b1;
        end
    end

    // address split into tag and set
    logic [3:0]              sb_eff;
    logic [6:0]              shift;
    logic [ADDRESS_BITS-1:0] tag;
    logic [ADDRESS_BITS-1:0] blk;
    logic [SET_W-1:0]        set_idx;

    always_comb begin
        sb_eff = (int'(r_set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, r_set_bits};
        shift  = {3'b000, sb_eff} + {1'b0, r_block_bits};
        tag    = (int'(shift) >= ADDRESS_BITS) ? '0 : (r_addr >> shift);
        blk    = r_addr >> r_block_bits;
        for (int i = 0; i < SET_W; i++) begin
            set_idx[i] = blk[i] && (i < int'(sb_eff));
        end
    end

    // clear sweep row counter
    logic [SET_W-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    assign o_status.clr_done = (r_clr_row == SET_W'(NUM_SETS - 1));

    // set store, one row per set
    logic [MAX_WAYS-1:0]                   mem_valid [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      mem_stamp [NUM_SETS];

    logic [MAX_WAYS-1:0]                   r_rd_valid;
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      r_rd_stamp;

    logic [MAX_WAYS-1:0]                   wr_valid;
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] wr_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      wr_stamp;
    logic [SET_W-1:0]                      wr_row;
    logic                                  mem_we;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_valid[wr_row] <= wr_valid;
            mem_tag[wr_row]   <= wr_tag;
            mem_stamp[wr_row] <= wr_stamp;
        end
        if (i_cmd.mem_re) begin
            r_rd_valid <= mem_valid[set_idx];
            r_rd_tag   <= mem_tag[set_idx];
            r_rd_stamp <= mem_stamp[set_idx];
        end
    end

    // way lookup over the row just read
    logic [MAX_WAYS-1:0] way_en;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;

    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            way_en[i]   = (i == 0) || (i < int'(r_ways));
            hit_vec[i]  = way_en[i] && r_rd_valid[i] && (r_rd_tag[i] == tag);
            free_vec[i] = way_en[i] && !r_rd_valid[i];
        end
        // lowest matching way wins
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_way = WAY_W'(i);
            end
            if (free_vec[i]) begin
                free_way = WAY_W'(i);
            end
        end
    end

    // oldest-stamp tree, lower way kept on a tie
    logic [KEY_W-1:0] lru_key [LVLS+1][PAD];
    logic [WAY_W-1:0] lru_idx [LVLS+1][PAD];

    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            for (int i = 0; i < PAD; i++) begin
                lru_key[l][i] = '1;
                lru_idx[l][i] = '0;
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            lru_key[0][i] = {!way_en[i], r_rd_stamp[i]};
            lru_idx[0][i] = WAY_W'(i);
        end
        for (int l = 1; l <= LVLS; l++) begin
            for (int i = 0; i < (PAD >> l); i++) begin
                if (lru_key[l-1][2*i+1] < lru_key[l-1][2*i]) begin
                    lru_key[l][i] = lru_key[l-1][2*i+1];
                    lru_idx[l][i] = lru_idx[l-1][2*i+1];
                end else begin
                    lru_key[l][i] = lru_key[l-1][2*i];
                    lru_idx[l][i] = lru_idx[l-1][2*i];
                end
            end
        end
    end

    // lookup results
    logic             r_hit;
    logic             r_free;
    logic [WAY_W-1:0] r_hit_way;
    logic [WAY_W-1:0] r_free_way;
    logic [WAY_W-1:0] r_lru_way;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_hit      <= |hit_vec;
            r_free     <= |free_vec;
            r_hit_way  <= hit_way;
            r_free_way <= free_way;
            r_lru_way  <= lru_idx[LVLS][0];
        end
    end

    // row update and outcome
    logic [WAY_W-1:0] pick_way;
    t_outcome         outcome;

    always_comb begin
        if (r_hit) begin
            pick_way = r_hit_way;
            outcome  = OUT_HIT;
        end else if (r_free) begin
            pick_way = r_free_way;
            outcome  = OUT_FILL;
        end else begin
            pick_way = r_lru_way;
            outcome  = OUT_EVICT;
        end
        mem_we = i_cmd.clr_we || i_cmd.commit;
        wr_row = i_cmd.clr_we ? r_clr_row : set_idx;
        if (i_cmd.clr_we) begin
            wr_valid = '0;
            wr_tag   = '0;
            wr_stamp = '0;
        end else begin
            wr_valid           = r_rd_valid;
            wr_tag             = r_rd_tag;
            wr_stamp           = r_rd_stamp;
            wr_valid[pick_way] = 1'b1;
            wr_tag[pick_way]   = tag;
            wr_stamp[pick_way] = r_stamp;
        end
    end

    // running totals, saturating
    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_misses;
    logic [TOTAL_W-1:0] r_evicts;
    logic [TOTAL_W-1:0] n_hits;
    logic [TOTAL_W-1:0] n_misses;
    logic [TOTAL_W-1:0] n_evicts;

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (outcome == OUT_HIT) begin
            n_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;
        end else begin
            n_misses = (r_misses == '1) ? r_misses : r_misses + 1'b1;
        end
        if (outcome == OUT_EVICT) begin
            n_evicts = (r_evicts == '1) ? r_evicts : r_evicts + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (i_cmd.commit) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
        end
    end

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.outcome        <= outcome;
            r_out.last           <= i_cmd.last;
            r_out.hit_total      <= n_hits;
            r_out.miss_total     <= n_misses;
            r_out.eviction_total <= n_evicts;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_lookup.sv =====
// flow: after an input transfer the set row is read, compared and written back, and
//   the result is registered; a modify then repeats read, compare and write back
//   for its second result; a new access is taken only once the last write back is
//   done, and the write back waits while the result register is still full
// reset: synchronous, active low; afterwards a sweep clears the set store, all
//   2**MAX_SET_BITS rows (64 by default), with input ready low and config taken
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_lookup
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/salc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_checker
    import salc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // reset empties the result slot and starts the clear sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("result or input ready right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an input transfer");

    // totals never go back
    a_totals_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid
            || (i_out_data.hit_total >= $past(i_out_data.hit_total)
            && i_out_data.miss_total >= $past(i_out_data.miss_total)
            && i_out_data.eviction_total >= $past(i_out_data.eviction_total)))
        else $error("running total decreased");

    // every eviction is a miss
    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.eviction_total <= i_out_data.miss_total)
        else $error("more evictions than misses");

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/sv/salc_lookup_checker.sv =====
`timescale 1ns / 1ps

module salc_lookup_checker
    import salc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_item             i_out_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int SETB       = MAX_SET_BITS_DEF;
    localparam int WAYS       = MAX_WAYS_DEF;
    localparam int LINES      = (1 << SETB) * WAYS;
    localparam int REPORT_MAX = 10;

    // shadow copy of the set store, line = set * WAYS + way
    logic               line_ok   [LINES];
    logic [ADDR_W-1:0]  line_key  [LINES];
    logic [STAMP_W-1:0] line_seen [LINES];
    logic [STAMP_W-1:0] use_clock;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;

    // shadow configuration
    logic [2:0] cfg_set_bits;
    logic [3:0] cfg_ways;
    logic [5:0] cfg_block_bits;

    // lookup results still owed by the block, oldest first
    t_out_item due_lookups[$];
    int        fails     = 0;
    int        delivered = 0;
    int        owed      = 0;

    assign o_fail_count = fails;
    assign o_pending    = owed;

    // saturating increment for stamps and totals
    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // one access against the shadow store, updates it and the totals
    function automatic t_outcome cache_access(input logic [ADDR_W-1:0] addr);
        int                 sb;
        int                 nw;
        int                 shift;
        int                 base;
        int                 pick;
        int                 w;
        bit                 free_found;
        logic [ADDR_W-1:0]  tag;
        logic [ADDR_W-1:0]  set_idx;
        logic [STAMP_W-1:0] oldest;
        t_outcome           res;

        // out-of-range settings clamp to what the store holds
        sb = (cfg_set_bits > SETB) ? SETB : int'(cfg_set_bits);
        nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
        shift = sb + int'(cfg_block_bits);
        tag = (shift >= ADDR_W) ? '0 : (addr >> shift);
        set_idx = (addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
        base = int'(set_idx) * WAYS;

        // lowest matching valid way wins
        for (w = 0; w < nw; w++) begin
            if (line_ok[base + w] && line_key[base + w] == tag) begin
                line_seen[base + w] = use_clock;
                hits = sat_bump(hits);
                return OUT_HIT;
            end
        end

        misses = sat_bump(misses);
        pick = base;
        free_found = 1'b0;
        for (w = 0; w < nw; w++) begin
            if (!free_found && !line_ok[base + w]) begin
                pick = base + w;
                free_found = 1'b1;
            end
        end

        if (free_found) begin
            res = OUT_FILL;
        end else begin
            // least recently used, ties to the lowest way
            oldest = line_seen[base];
            for (w = 1; w < nw; w++) begin
                if (line_seen[base + w] < oldest) begin
                    oldest = line_seen[base + w];
                    pick = base + w;
                end
            end
            evictions = sat_bump(evictions);
            res = OUT_EVICT;
        end

        line_ok[pick]   = 1'b1;
        line_key[pick]  = tag;
        line_seen[pick] = use_clock;
        return res;
    endfunction

    function automatic t_out_item lookup_result(input t_outcome res, input logic is_last);
        t_out_item r;
        r.outcome        = res;
        r.last           = is_last;
        r.hit_total      = hits;
        r.miss_total     = misses;
        r.eviction_total = evictions;
        return r;
    endfunction

    task automatic report_lookup(input bit have_want, input t_out_item want,
                                 input t_out_item got);
        fails++;
        if (fails <= REPORT_MAX) begin
            if (have_want)
                $display("result %0d differs: expected outcome %0d last %0d totals %0d/%0d/%0d,",
                         delivered, want.outcome, want.last, want.hit_total,
                         want.miss_total, want.eviction_total);
            else
                $display("result %0d arrived with nothing outstanding,", delivered);
            $display("    got outcome %0d last %0d totals %0d/%0d/%0d",
                     got.outcome, got.last, got.hit_total, got.miss_total,
                     got.eviction_total);
        end
    endtask

    // watch all three channels at each clock edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_outcome  res;
        int        i;

        if (!i_rst_n) begin
            for (i = 0; i < LINES; i++) begin
                line_ok[i]   = 1'b0;
                line_key[i]  = '0;
                line_seen[i] = '0;
            end
            use_clock      = '0;
            hits           = '0;
            misses         = '0;
            evictions      = '0;
            cfg_set_bits   = 3'd0;
            cfg_ways       = 4'd1;
            cfg_block_bits = 6'd0;
            due_lookups.delete();
        end else begin
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   cfg_set_bits   = i_cfg_data[2:0];
                    CFG_WAYS:       cfg_ways       = i_cfg_data[3:0];
                    CFG_BLOCK_BITS: cfg_block_bits = i_cfg_data[5:0];
                    default: ;
                endcase
            end

            // result transfer, compared with the oldest owed result
            if (i_out_valid && i_out_ready) begin
                if (due_lookups.size() == 0) begin
                    report_lookup(1'b0, '0, i_out_data);
                end else begin
                    want = due_lookups.pop_front();
                    if (i_out_data.outcome !== want.outcome ||
                        i_out_data.last !== want.last ||
                        i_out_data.hit_total !== want.hit_total ||
                        i_out_data.miss_total !== want.miss_total ||
                        i_out_data.eviction_total !== want.eviction_total)
                        report_lookup(1'b1, want, i_out_data);
                end
                delivered++;
            end

            // access transfer: one stamp per item, a modify looks up twice
            if (i_in_valid && i_in_ready) begin
                use_clock = sat_bump(use_clock);
                if (i_in_data.operation == OP_MODIFY) begin
                    res = cache_access(i_in_data.address);
                    due_lookups.push_back(lookup_result(res, 1'b0));
                end
                res = cache_access(i_in_data.address);
                due_lookups.push_back(lookup_result(res, 1'b1));
            end
        end
        owed = due_lookups.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import salc_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int LONG_HOLD = 300;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 102;
    localparam int SETTLE    = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycles = 0;

    // idle controls for the sender and the receiver
    bit tx_idling    = 1'b1;
    bit rx_idling    = 1'b1;
    bit hold_request = 1'b0;

    // current effective geometry, used to aim addresses at few sets and tags
    int                eff_sb   = 0;
    int                eff_ways = 1;
    int                cur_bb   = 0;
    logic [ADDR_W-1:0] tag_base = '0;

    always #1 clk = ~clk;

    set_assoc_lru_cache_lookup dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    salc_lookup_checker lookup_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold on request
    initial begin : receiver
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // offer one access, valid stays up after the transfer until the next call
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr);
        t_in_item item;
        item.operation = op;
        item.address   = addr;
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    // reconfigure while the block is idle
    task automatic set_config(input int sb, input int ways, input int bb);
        wait_drained();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS, ways);
        write_reg(CFG_BLOCK_BITS, bb);
        cfg_valid <= 1'b0;
        eff_sb   = (sb > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : sb;
        eff_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways);
        cur_bb   = bb;
        tag_base = {$urandom, $urandom};
    endtask

    // mostly a few tags in a few sets so hits and evictions are common
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] addr;
        int                shift;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        tag = tag_base + ADDR_W'($urandom_range(0, eff_ways + 2));
        set_idx = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, 63))
                                              : ADDR_W'($urandom_range(0, 1));
        set_idx = set_idx & ((64'd1 << eff_sb) - 64'd1);
        addr = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
        addr = addr | (set_idx << cur_bb);
        shift = eff_sb + cur_bb;
        if (shift < ADDR_W)
            addr = addr | (tag << shift);
        return addr;
    endfunction

    initial begin : stimulus
        int p;
        int n;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // two sets of two ways, 16-byte lines: fills, hit, eviction
        set_config(1, 2, 4);
        send_access(OP_SINGLE, 64'h0);
        send_access(OP_SINGLE, 64'h0);
        send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_SINGLE, 64'h20);
        send_access(OP_SINGLE, 64'h40);
        send_access(OP_MODIFY, 64'h10);
        send_access(OP_SINGLE, 64'h20);

        // shrink to one way then widen again: same tag sits in two ways
        set_config(1, 1, 4);
        send_access(OP_SINGLE, 64'h20);
        set_config(1, 2, 4);
        send_access(OP_SINGLE, 64'h20);
        send_access(OP_MODIFY, 64'h60);

        // set bits past the maximum, zero ways, shift wider than the address
        set_config(7, 0, 63);
        send_access(OP_SINGLE, 64'h0);
        send_access(OP_SINGLE, 64'h8000_0000_0000_0000);
        send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);

        // one set, way count above the maximum
        set_config(0, 15, 0);
        send_access(OP_SINGLE, 64'h0);
        send_access(OP_SINGLE, 64'h1);
        send_access(OP_MODIFY, 64'h5555_5555_5555_5555);
        send_access(OP_SINGLE, 64'hAAAA_AAAA_AAAA_AAAA);

        // largest legal block offset
        set_config(3, 8, 57);
        send_access(OP_SINGLE, 64'hFE00_0000_0000_0000);
        send_access(OP_MODIFY, 64'h01FF_FFFF_FFFF_FFFF);
        send_access(OP_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF);

        // random phases, each under its own geometry
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(6, 8, 0);
                1: set_config(0, 1, 57);
                2: set_config(2, 4, 6);
                default: set_config(
                    $urandom_range(0, 7),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 12));
            endcase
            // long result stall so the block backs up into the input
            if (p == 2)
                hold_request = 1'b1;
            // last stretch runs at full rate
            if (p == PHASES - 1) begin
                tx_idling = 1'b0;
                rx_idling = 1'b0;
            end
            for (n = 0; n < PHASE_LEN; n++)
                send_access($urandom_range(0, 1) ? OP_MODIFY : OP_SINGLE, pick_address());
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
